FILE: src/sha_pkg.sv
// shared types, constants and round functions for the sha-256 digest unit
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS  = 64;
    localparam int COUNT_W = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic write_pad;
        logic start_block;
        logic round_step;
        logic fold;
        logic restart;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic block_full;
        logic pad_done;
        logic rounds_done;
        logic final_block;
    } status_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

FILE: src/sha_if.sv
// valid/ready channel interfaces for message bytes and digests
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;
    modport source (output valid, output digest_bits_255_192, output digest_bits_191_128,
                    output digest_bits_127_64, output digest_bits_63_0, input ready);
    modport sink   (input valid, input digest_bits_255_192, input digest_bits_191_128,
                    input digest_bits_127_64, input digest_bits_63_0, output ready);
endinterface

FILE: src/sha_ctrl.sv
// controller state machine: byte collection, padding, rounds, digest hand-off
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_has_byte,
    input  logic    in_last,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   closing_reg, closing_next;

    logic accept;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        closing_next = closing_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    closing_next = in_last;
                    if (in_has_byte && status.block_full)
                        state_next = ST_ROUND;
                    else if (in_last)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (status.pad_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.rounds_done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!closing_reg)
                    state_next = ST_COLLECT;
                else if (status.final_block)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next   = ST_COLLECT;
                    closing_next = 1'b0;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = accept && in_has_byte;
                cmd.start_block = accept && in_has_byte && status.block_full;
            end
            ST_PAD:
            begin
                cmd.write_pad   = 1'b1;
                cmd.start_block = status.pad_done;
            end
            ST_ROUND: cmd.round_step = 1'b1;
            ST_FOLD:  cmd.fold = 1'b1;
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.emit    = 1'b1;
                cmd.restart = out_ready;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            closing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
        end
    end

    a_ready_only_collect: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_COLLECT)
        else $error("input taken outside collect");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_emit_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_FOLD)
        else $error("digest shown without a final fold");
    a_restart_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |-> out_valid && out_ready)
        else $error("restart without digest hand-off");

endmodule

FILE: src/sha_datapath.sv
// message buffer, padding writer, schedule and round datapath
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [63:0] digest_bits_255_192,
    output logic [63:0] digest_bits_191_128,
    output logic [63:0] digest_bits_127_64,
    output logic [63:0] digest_bits_63_0
);

    // message block as 16 words, doubles as the schedule window
    word_t w_reg [16];
    word_t h_reg [8];
    word_t v_reg [8];
    logic [COUNT_W-1:0] count_reg;
    logic [5:0] pad_pos_reg;
    logic [6:0] round_reg;
    logic       final_reg;

    // pad phase: first pass starts at the count position; final pass covers length
    logic pad_first_reg;
    logic fits;

    logic [5:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [63:0] bit_len;

    assign bit_len = {count_reg[COUNT_W-4:0], 3'b000};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_pos  = count_reg[5:0];
        wr_byte = data_byte;
        if (cmd.take_byte)
            wr_en = 1'b1;
        else if (cmd.write_pad)
        begin
            wr_en  = 1'b1;
            wr_pos = pad_first_reg ? count_reg[5:0] : pad_pos_reg;
            if (pad_first_reg)
                wr_byte = PAD_BYTE;
            else if (pad_pos_reg >= LEN_POS && final_reg)
                wr_byte = bit_len[6'(63 - 8 * (pad_pos_reg - LEN_POS)) -: 8];
            else
                wr_byte = 8'h00;
        end
    end

    assign fits = (count_reg[5:0] < LEN_POS);

    assign status.block_full  = (count_reg[5:0] == 6'd63);
    assign status.pad_done    = cmd.write_pad && (wr_pos == 6'd63);
    assign status.rounds_done = (round_reg == 7'(ROUNDS - 1));
    // length is in the block only once a pad pass has run for this message
    assign status.final_block = final_reg && !pad_first_reg;

    word_t s0w, s1w, t1, t2, wnew, wcur;
    assign wcur = w_reg[0];
    assign s0w  = sig0(w_reg[1]);
    assign s1w  = sig1(w_reg[14]);
    assign wnew = s1w + w_reg[9] + s0w + w_reg[0];
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg[5:0]] + wcur;
    assign t2 = bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            w_reg[wr_pos[5:2]][5'(31 - 8 * wr_pos[1:0]) -: 8] <= wr_byte;
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
        end
        if (cmd.start_block)
            v_reg <= h_reg;
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= INIT_H;
            count_reg     <= '0;
            pad_pos_reg   <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            pad_first_reg <= 1'b1;
        end
        else
        begin
            if (cmd.take_byte)
                count_reg <= count_reg + 1'b1;
            if (cmd.write_pad)
            begin
                if (pad_first_reg)
                begin
                    // first pad cycle writes 0x80 at the count position
                    pad_first_reg <= 1'b0;
                    pad_pos_reg   <= count_reg[5:0] + 1'b1;
                    if (count_reg[5:0] == 6'd63)
                        final_reg <= 1'b0;
                    else
                        final_reg <= fits;
                end
                else
                    pad_pos_reg <= pad_pos_reg + 1'b1;
            end
            if (cmd.round_step)
                round_reg <= round_reg + 1'b1;
            else
                round_reg <= '0;
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                // second padding block starts clean with length at its end
                pad_pos_reg <= '0;
                final_reg   <= 1'b1;
            end
            if (cmd.restart)
            begin
                h_reg         <= INIT_H;
                count_reg     <= '0;
                pad_pos_reg   <= '0;
                final_reg     <= 1'b0;
                pad_first_reg <= 1'b1;
            end
        end
    end

    assign digest_bits_255_192 = {h_reg[0], h_reg[1]};
    assign digest_bits_191_128 = {h_reg[2], h_reg[3]};
    assign digest_bits_127_64  = {h_reg[4], h_reg[5]};
    assign digest_bits_63_0    = {h_reg[6], h_reg[7]};

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.round_step |=> round_reg == '0)
        else $error("round counter not cleared");
    a_no_byte_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_byte && cmd.write_pad))
        else $error("byte write during padding");
    a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> $past(cmd.round_step))
        else $error("fold without rounds");

endmodule

FILE: src/sha256_message_digest_unit.sv
// sha-256 digest unit top level: controller plus datapath
// each byte request is taken while collecting; a full block then runs the rounds and one fold
// closing request: pad bytes from the count position to byte 63, then the rounds and one
// fold, then a pad pass over bytes 0 to 63, rounds and a fold more if the length does not
// fit; a closing byte that fills a block is compressed first; the digest waits until taken
// input is refused while padding, while a block compresses or while a digest waits
// rst_n clears to the initial hash value with no bytes held and zero count
module sha256_message_digest_unit
    import sha_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    sha_in_if.sink   in_ch,
    sha_out_if.source out_ch
);

    cmd_t    cmd;
    status_t status;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_has_byte(in_ch.has_byte),
        .in_last    (in_ch.last),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    sha_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .data_byte          (in_ch.data_byte),
        .cmd                (cmd),
        .status             (status),
        .digest_bits_255_192(out_ch.digest_bits_255_192),
        .digest_bits_191_128(out_ch.digest_bits_191_128),
        .digest_bits_127_64 (out_ch.digest_bits_127_64),
        .digest_bits_63_0   (out_ch.digest_bits_63_0)
    );

endmodule

FILE: sim/sha_tb_pkg.sv
`timescale 1ns / 1ps
// digest scoreboard: models sha-256 on accepted requests and checks digests
package sha_tb_pkg;

    import sha_pkg::*;

    typedef struct packed {
        logic [63:0] d3;
        logic [63:0] d2;
        logic [63:0] d1;
        logic [63:0] d0;
    } digest_t;

    class digest_scoreboard;
        word_t       hval [8];
        logic [7:0]  blk [64];
        logic [63:0] nbytes;
        digest_t     pending [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                hval[i] = INIT_H[i];
            nbytes = '0;
        endfunction

        function word_t rr(word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            word_t w [64];
            word_t v [8];
            word_t t1;
            word_t t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            for (int i = 0; i < 8; i++)
                v[i] = hval[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hval[i] = hval[i] + v[i];
        endfunction

        function void note_request(logic [7:0] b, logic hb, logic lst);
            int          p;
            logic [63:0] bits;
            if (hb)
            begin
                p = int'(nbytes[5:0]);
                blk[p] = b;
                nbytes = nbytes + 1;
                if (p == 63)
                    compress();
            end
            if (!lst)
                return;
            bits = nbytes << 3;
            p = int'(nbytes[5:0]);
            blk[p] = PAD_BYTE;
            p++;
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk[p] = 8'h00;
                    p++;
                end
                compress();
                p = 0;
            end
            while (p < 56)
            begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = bits[63-8*i -: 8];
            compress();
            pending.push_back({hval[0], hval[1], hval[2], hval[3],
                               hval[4], hval[5], hval[6], hval[7]});
            restart();
        endfunction

        function void check_digest(digest_t got);
            digest_t exp;
            if (pending.size() == 0)
            begin
                $error("digest with no request pending: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.d3 !== exp.d3)
            begin
                $error("digest_bits_255_192 expected %h actual %h", exp.d3, got.d3);
                errors++;
            end
            if (got.d2 !== exp.d2)
            begin
                $error("digest_bits_191_128 expected %h actual %h", exp.d2, got.d2);
                errors++;
            end
            if (got.d1 !== exp.d1)
            begin
                $error("digest_bits_127_64 expected %h actual %h", exp.d1, got.d1);
                errors++;
            end
            if (got.d0 !== exp.d0)
            begin
                $error("digest_bits_63_0 expected %h actual %h", exp.d0, got.d0);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench top for the sha-256 digest unit
module tb
    import sha_tb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_message_digest_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    digest_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, optional long hold-off
    always @(negedge clk)
    begin
        if (hold_recv)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_digest({out_ch.digest_bits_255_192, out_ch.digest_bits_191_128,
                             out_ch.digest_bits_127_64, out_ch.digest_bits_63_0});
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays high after a request until the next idle gap or drain
    task automatic send_request(logic [7:0] b, logic hb, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte  <= hb;
        in_ch.last      <= lst;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(b, hb, lst);
        @(negedge clk);
    endtask

    task automatic send_message(int len, bit empty_close);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom_range(255)), 1'b1, (i == len - 1) && !empty_close);
        if (empty_close || len == 0)
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int n);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            else
            begin
                len = (pick < 15) ? $urandom_range(200, 64) : $urandom_range(70);
                send_message(len, $urandom_range(3) == 0);
                sent += len + 1;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        hold_recv = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, idle item, extreme bytes, padding boundaries
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        drain();

        send_idle_pct = 12;
        recv_idle_pct = 56;
        random_phase(140);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_recv = 1'b1;
                repeat (600) @(negedge clk);
                hold_recv = 1'b0;
            end
            begin
                send_message(3, 1'b0);
                send_message(5, 1'b0);
                send_message(2, 1'b1);
            end
        join
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 12;
        random_phase(140);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(140);
        drain();
        repeat (300) @(negedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sha256_message_digest_unit.f
src/sha_pkg.sv
src/sha_if.sv
src/sha_ctrl.sv
src/sha_datapath.sv
src/sha256_message_digest_unit.sv
sim/sha_tb_pkg.sv
sim/tb.sv
